>>> rtl/clex_pkg.sv
// Package for the cycle-notation lexer: token codes, character codes and
// the token and step types that pass between the lexer core and the output buffer.
// No dependencies.
package clex_pkg;

  localparam int VALUE_BITS_DEF = 16;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NUM   = 2'd0;
  localparam kind_t KIND_OPEN  = 2'd1;
  localparam kind_t KIND_CLOSE = 2'd2;
  localparam kind_t KIND_BAD   = 2'd3;

  localparam logic [7:0] CH_EOS   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] DIGITS_MAX = 8'hFF;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic [7:0]  digit_count;
    logic [7:0]  bad_char;
    logic        overflow;
    logic        last;
  } tok_t;

  // Tokens caused by one character: cnt of 0..2, first in a, second in b.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       a;
    tok_t       b;
  } step_t;

endpackage

>>> rtl/clex_in_if.sv
// Input channel of the lexer: one character byte per transaction.
// Depends on nothing.
interface clex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

>>> rtl/clex_out_if.sv
// Result channel of the lexer: one token per transaction.
// Depends on clex_pkg.
interface clex_out_if;
  import clex_pkg::*;

  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] value;
  logic [7:0]  digit_count;
  logic [7:0]  bad_char;
  logic        overflow;
  logic        last;

  modport source (output valid, output kind, output value, output digit_count,
                  output bad_char, output overflow, output last, input ready);
  modport sink (input valid, input kind, input value, input digit_count,
                input bad_char, input overflow, input last, output ready);
endinterface

>>> rtl/clex_core.sv
// Lexer core: state and number accumulator registers, and the single-pass
// logic that turns one character into zero, one or two tokens.
// Depends on clex_pkg.
module clex_core #(
  parameter int VALUE_BITS = clex_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      ch,
  output clex_pkg::step_t step
);
  import clex_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NUM  = 2'd1;
  localparam logic [1:0] ST_HALT = 2'd2;
  localparam int PW = VALUE_BITS + 4;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] acc_value_r, acc_value_nxt;
  logic [7:0]            acc_digits_r, acc_digits_nxt;
  logic                  acc_ovf_r, acc_ovf_nxt;

  logic                  in_num, halted, is_digit, is_delim, is_paren;
  logic [VALUE_BITS-1:0] base_val;
  logic [7:0]            base_dig;
  logic                  base_ovf;
  logic [PW-1:0]         prod;
  logic                  sat;
  logic [VALUE_BITS+15:0] val_ext;
  tok_t                  num_tok, paren_tok;

  always_comb begin
    in_num   = (state_r == ST_NUM);
    halted   = (state_r == ST_HALT);
    is_digit = ch inside {[CH_ZERO:CH_NINE]};
    is_paren = ch inside {CH_OPEN, CH_CLOSE};
    is_delim = ch inside {CH_SPACE, CH_NL, CH_EOS, CH_OPEN, CH_CLOSE};

    base_val = in_num ? acc_value_r : '0;
    base_dig = in_num ? acc_digits_r : 8'd0;
    base_ovf = in_num ? acc_ovf_r : 1'b0;

    // value * 10 + digit as two shifts; the top four bits flag saturation
    prod = ({4'b0, base_val} << 3) + ({4'b0, base_val} << 1) + PW'(ch[3:0]);
    sat  = |prod[PW-1:VALUE_BITS];

    val_ext = {16'b0, acc_value_r};

    num_tok.kind        = KIND_NUM;
    num_tok.value       = val_ext[15:0];
    num_tok.digit_count = acc_digits_r;
    num_tok.bad_char    = 8'd0;
    num_tok.overflow    = acc_ovf_r;
    num_tok.last        = 1'b1;

    paren_tok      = '0;
    paren_tok.kind = (ch == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
    paren_tok.last = 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    acc_value_nxt  = acc_value_r;
    acc_digits_nxt = acc_digits_r;
    acc_ovf_nxt    = acc_ovf_r;
    step           = '0;

    if (halted) begin
      if (ch == CH_EOS) begin
        state_nxt      = ST_IDLE;
        acc_value_nxt  = '0;
        acc_digits_nxt = 8'd0;
        acc_ovf_nxt    = 1'b0;
      end
    end else if (is_digit) begin
      acc_value_nxt  = sat ? '1 : prod[VALUE_BITS-1:0];
      acc_ovf_nxt    = base_ovf | sat;
      acc_digits_nxt = (base_dig == DIGITS_MAX) ? base_dig : base_dig + 8'd1;
      state_nxt      = ST_NUM;
    end else if (is_delim) begin
      if (in_num) begin
        step.a      = num_tok;
        step.a.last = !is_paren;
        step.cnt    = 2'd1;
      end
      if (is_paren) begin
        if (in_num) begin
          step.b   = paren_tok;
          step.cnt = 2'd2;
        end else begin
          step.a   = paren_tok;
          step.cnt = 2'd1;
        end
      end
      state_nxt      = ST_IDLE;
      acc_value_nxt  = '0;
      acc_digits_nxt = 8'd0;
      acc_ovf_nxt    = 1'b0;
    end else begin
      // invalid character carries any pending digits, then halt until end of string
      if (in_num) begin
        step.a = num_tok;
      end
      step.a.kind     = KIND_BAD;
      step.a.bad_char = ch;
      step.a.last     = 1'b1;
      step.cnt        = 2'd1;
      state_nxt       = ST_HALT;
      acc_value_nxt   = '0;
      acc_digits_nxt  = 8'd0;
      acc_ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      acc_value_r  <= '0;
      acc_digits_r <= 8'd0;
      acc_ovf_r    <= 1'b0;
    end else if (accept) begin
      state_r      <= state_nxt;
      acc_value_r  <= acc_value_nxt;
      acc_digits_r <= acc_digits_nxt;
      acc_ovf_r    <= acc_ovf_nxt;
    end
  end

  a_two_tok_shape: assert property (@(posedge clk) disable iff (!rst_n)
    step.cnt == 2'd2 |-> step.a.kind == KIND_NUM && !step.a.last && step.b.last)
    else $error("two-token step with wrong token shape");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted |-> step.cnt == 2'd0)
    else $error("token produced while halted");

  a_digit_enters_num: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_digit && !halted |=> state_r == ST_NUM)
    else $error("digit did not enter number state");

endmodule

>>> rtl/clex_outbuf.sv
// Output buffer: result register plus one pending slot for the second token
// of a character that ends a number with a parenthesis.
// Depends on clex_pkg.
module clex_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clex_pkg::step_t step,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output clex_pkg::tok_t  out_tok
);
  import clex_pkg::*;

  logic out_valid_r, pend_valid_r;
  tok_t out_tok_r, pend_tok_r;
  logic pop;

  assign pop       = out_valid_r && out_ready;
  assign in_ready  = !pend_valid_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (push && step.cnt != 2'd0) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= (step.cnt == 2'd2);
    end else if (pop) begin
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && step.cnt != 2'd0) begin
      out_tok_r  <= step.a;
      pend_tok_r <= step.b;
    end else if (pop && pend_valid_r) begin
      out_tok_r <= pend_tok_r;
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending token without a token in the result register");

  a_two_fills_pend: assert property (@(posedge clk) disable iff (!rst_n)
    push && step.cnt == 2'd2 |=> pend_valid_r && out_valid_r)
    else $error("second token not held");

  a_no_push_over_pend: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !pend_valid_r && (!out_valid_r || pop))
    else $error("transaction accepted over a held token");

endmodule

>>> rtl/cycle_notation_lexer_top.sv
// Cycle-notation lexer, top level: one character per input transaction.
// The first token a character yields is on the result port in the cycle after the character is accepted.
// Throughput: one character per cycle while the result port is ready; a character that closes a number with a
// parenthesis yields two tokens and holds input off while the second waits in the pending slot.
// Reset (synchronous, active low) returns the lexer to idle, clears the accumulator and empties the buffer.
module cycle_notation_lexer_top #(
  parameter int VALUE_BITS = clex_pkg::VALUE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  clex_in_if.sink    in_chan,
  clex_out_if.source out_chan
);
  import clex_pkg::*;

  logic  in_ready;
  logic  accept;
  step_t step;
  tok_t  out_tok;
  logic  out_valid;

  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  clex_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_chan.ch),
    .step   (step)
  );

  clex_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .step      (step),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_tok   (out_tok)
  );

  assign out_chan.valid       = out_valid;
  assign out_chan.kind        = out_tok.kind;
  assign out_chan.value       = out_tok.value;
  assign out_chan.digit_count = out_tok.digit_count;
  assign out_chan.bad_char    = out_tok.bad_char;
  assign out_chan.overflow    = out_tok.overflow;
  assign out_chan.last        = out_tok.last;

endmodule
